/* hw/rtl/bbst_pkg.sv */
// ----------------------------------------------------------------------------
// Bump buffer slot tracker package
// Shared word types, command codes and defaults for the slot tracker block.
// ----------------------------------------------------------------------------
package bbst_pkg;

	// Default table size and buffer capacity after reset.
	localparam int unsigned SlotCountDef  = 64;
	localparam logic [24:0] BufResetBytes = 25'd1048576;

	// Request codes. The two unused codes behave as a query.
	typedef enum logic [2:0] {
		MODE_RESERVE  = 3'd0,
		MODE_ALLOC    = 3'd1,
		MODE_COMPLETE = 3'd2,
		MODE_RELEASE  = 3'd3,
		MODE_RESET    = 3'd4,
		MODE_QUERY    = 3'd5
	} mode_t;

	// Request word.
	typedef struct packed {
		logic [2:0]  mode;
		logic [24:0] length;
		logic [7:0]  slot_index;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic        status;
		logic [23:0] offset;
		logic [7:0]  granted_slot;
		logic        slot_tracked;
		logic        submit_ready;
		logic [15:0] active_slots;
		logic [31:0] epoch;
		logic [24:0] used_bytes;
	} out_word_t;

	// Command to the slot table for one request.
	typedef struct packed {
		logic       alloc;
		logic       complete;
		logic       release_slot;
		logic       clear;
		logic [7:0] index;
	} tbl_cmd_t;

	// Slot table answer, reflecting the state after the request.
	typedef struct packed {
		logic [7:0]  granted;
		logic        tracked;
		logic        submit_ready;
		logic [15:0] active;
	} tbl_res_t;

endpackage

/* hw/rtl/bbst_alloc.sv */
// ----------------------------------------------------------------------------
// Bump allocator
// Holds the buffer capacity and the used byte count and checks whether a
// reservation fits.
// ----------------------------------------------------------------------------
module bbst_alloc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [24:0] cfg_wr_data,
	input  logic        go,
	input  logic        take,
	input  logic        clear,
	input  logic [24:0] length,
	output logic        fits,
	output logic [24:0] used_cur,
	output logic [24:0] used_next
);

	logic [24:0] cap_q;
	logic [24:0] used_q;
	logic [25:0] sum;

	// The sum carries one extra bit so that the compare never wraps.
	always_comb begin
		sum       = {1'b0, used_q} + {1'b0, length};
		fits      = (sum <= {1'b0, cap_q});
		used_cur  = used_q;
		used_next = used_q;
		if (clear) begin
			used_next = '0;
		end else if (take && fits) begin
			used_next = sum[24:0];
		end
	end

	// Capacity register. The user must write it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bbst_pkg::BufResetBytes;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Used count advances once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (go) begin
			used_q <= used_next;
		end
	end

endmodule

/* hw/rtl/bbst_table.sv */
// ----------------------------------------------------------------------------
// Slot table
// Allocated and done flags per slot, the next slot id and the active count.
// ----------------------------------------------------------------------------
module bbst_table #(
	parameter int unsigned SLOT_COUNT = bbst_pkg::SlotCountDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  bbst_pkg::tbl_cmd_t  cmd,
	output bbst_pkg::tbl_res_t  res
);

	localparam int unsigned NW = $clog2(SLOT_COUNT + 1);
	localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [SLOT_COUNT-1:0] alloc_q, alloc_d;
	logic [SLOT_COUNT-1:0] done_q, done_d;
	logic [NW-1:0]         next_q, next_d;
	logic [15:0]           active_q, active_d;
	logic [8:0]            next_ext;
	logic                  idx_ok;
	logic [IW-1:0]         idx;
	logic [IW-1:0]         wr_id;

	assign next_ext = 9'(next_q);
	assign idx_ok   = ({1'b0, cmd.index} < 9'(SLOT_COUNT));
	assign idx      = cmd.index[IW-1:0];
	assign wr_id    = next_q[IW-1:0];

	// Next state of the table for the current request.
	always_comb begin
		alloc_d     = alloc_q;
		done_d      = done_q;
		next_d      = next_q;
		active_d    = active_q;
		res.granted = '0;
		res.tracked = 1'b0;
		priority if (cmd.clear) begin
			alloc_d  = '0;
			done_d   = '0;
			next_d   = '0;
			active_d = '0;
		end else if (cmd.alloc) begin
			if (next_ext < 9'(SLOT_COUNT)) begin
				alloc_d[wr_id] = 1'b1;
				done_d[wr_id]  = 1'b0;
				next_d         = next_q + 1'b1;
				if (active_q != 16'hFFFF) begin
					active_d = active_q + 16'd1;
				end
				res.granted = next_ext[7:0];
				res.tracked = 1'b1;
			end else begin
				// Table full: space is taken but the id wraps to zero untracked.
				next_d = '0;
			end
		end else if (cmd.complete && idx_ok) begin
			done_d[idx] = 1'b1;
		end else if (cmd.release_slot && idx_ok && alloc_q[idx]) begin
			alloc_d[idx] = 1'b0;
			if (active_q != 16'd0) begin
				active_d = active_q - 16'd1;
			end
		end else begin
			active_d = active_q;
		end
		res.active       = active_d;
		res.submit_ready = ~|(alloc_d & ~done_d);
	end

	// Table registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q  <= '0;
			done_q   <= '0;
			next_q   <= '0;
			active_q <= '0;
		end else if (go) begin
			alloc_q  <= alloc_d;
			done_q   <= done_d;
			next_q   <= next_d;
			active_q <= active_d;
		end
	end

endmodule

/* hw/rtl/bump_buffer_slot_tracker.sv */
// Path: an accepted word waits in the input register, and its result is loaded into the result register.
// Throughput: one word per cycle while the receiver does not stall; the input register feeds a single pass of logic
// that updates the allocator and slot table and loads the result register.
// Reset: arst_n clears the counters, the slot table, the epoch and both valid flags,
// and sets the buffer capacity to 1048576 bytes. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Bump buffer slot tracker
// Bump allocation over one buffer with per-slot completion tracking.
// ----------------------------------------------------------------------------
module bump_buffer_slot_tracker #(
	parameter int unsigned SLOT_COUNT = bbst_pkg::SlotCountDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [24:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  bbst_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output bbst_pkg::out_word_t out_word
);

	logic                valid_s1;
	bbst_pkg::in_word_t  word_s1;
	logic                out_valid_q;
	bbst_pkg::out_word_t out_word_q;
	logic [31:0]         epoch_q, epoch_d;
	logic                adv;
	logic                take;
	logic                is_alloc;
	logic                is_clear;
	logic                fits;
	logic [24:0]         used_cur;
	logic [24:0]         used_next;
	bbst_pkg::tbl_cmd_t  tcmd;
	bbst_pkg::tbl_res_t  tres;
	bbst_pkg::out_word_t result;

	// Handshake: the input register moves on when the result register is free.
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Request decode.
	always_comb begin
		take     = 1'b0;
		is_alloc = 1'b0;
		is_clear = 1'b0;
		tcmd     = '0;
		unique case (word_s1.mode)
			bbst_pkg::MODE_RESERVE: begin
				take = 1'b1;
			end
			bbst_pkg::MODE_ALLOC: begin
				take     = 1'b1;
				is_alloc = 1'b1;
			end
			bbst_pkg::MODE_COMPLETE: begin
				tcmd.complete = 1'b1;
			end
			bbst_pkg::MODE_RELEASE: begin
				tcmd.release_slot = 1'b1;
			end
			bbst_pkg::MODE_RESET: begin
				is_clear = 1'b1;
			end
			default: begin
				take = 1'b0;
			end
		endcase
		tcmd.alloc = is_alloc && fits;
		tcmd.clear = is_clear;
		tcmd.index = word_s1.slot_index;
	end

	bbst_alloc u_alloc (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.go          (adv),
		.take        (take),
		.clear       (is_clear),
		.length      (word_s1.length),
		.fits        (fits),
		.used_cur    (used_cur),
		.used_next   (used_next)
	);

	bbst_table #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (adv),
		.cmd    (tcmd),
		.res    (tres)
	);

	// Result assembly from the post-request state.
	always_comb begin
		epoch_d             = is_clear ? epoch_q + 32'd1 : epoch_q;
		result.status       = take && !fits;
		result.offset       = (take && fits) ? used_cur[23:0] : 24'd0;
		result.granted_slot = tres.granted;
		result.slot_tracked = tres.tracked;
		result.submit_ready = tres.submit_ready;
		result.active_slots = tres.active;
		result.epoch        = epoch_d;
		result.used_bytes   = used_next;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			epoch_q     <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				epoch_q     <= epoch_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
		if (adv) begin
			out_word_q <= result;
		end
	end

endmodule

/* tb/sv/tb_slot_tracker_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot tracker result checker
// Watches the request, result and capacity ports of the slot tracker. It keeps
// its own copy of the allocator and slot table, works out the result word for
// every accepted request, and compares each accepted result word field by field
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module tb_slot_tracker_check
	import bbst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [24:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_word_t    in_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_word_t   out_word,
	output int unsigned words_owed,
	output int unsigned fail_count
);

	localparam int unsigned SLOTS = SlotCountDef;

	// Mirror of the block state.
	logic [24:0]      cap_bytes;
	logic [24:0]      fill_bytes;
	int unsigned      id_cursor;
	logic [15:0]      live_count;
	logic [31:0]      gen_count;
	logic [SLOTS-1:0] held_map;
	logic [SLOTS-1:0] done_map;

	out_word_t        owed_results[$];
	out_word_t        oldest;
	int unsigned      errors;

	assign fail_count = errors;

	// Prints one line per mismatch and counts every one.
	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("slot tracker: %s got 0x%0h want 0x%0h at %0t ns",
			what, got, want, $time);
	endtask

	task automatic match_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			note_mismatch(what, got, want);
		end
	endtask

	// Applies one request to the mirror and returns the result word it yields.
	function automatic out_word_t allocate_step(input in_word_t w);
		out_word_t   r;
		logic [25:0] reach;
		logic        fits;
		r = '0;
		reach = {1'b0, fill_bytes} + {1'b0, w.length};
		fits = (reach <= {1'b0, cap_bytes});
		case (w.mode)
			MODE_RESERVE: begin
				if (fits) begin
					r.offset = fill_bytes[23:0];
					fill_bytes = reach[24:0];
				end else begin
					r.status = 1'b1;
				end
			end
			MODE_ALLOC: begin
				if (fits) begin
					r.offset = fill_bytes[23:0];
					fill_bytes = reach[24:0];
					// Past the last id the space is taken but nothing is recorded.
					if (id_cursor < SLOTS) begin
						held_map[id_cursor] = 1'b1;
						done_map[id_cursor] = 1'b0;
						if (live_count != 16'hFFFF) begin
							live_count = live_count + 16'd1;
						end
						r.granted_slot = id_cursor[7:0];
						r.slot_tracked = 1'b1;
						id_cursor = id_cursor + 1;
					end else begin
						id_cursor = 0;
					end
				end else begin
					r.status = 1'b1;
				end
			end
			MODE_COMPLETE: begin
				// A free entry still gets its done bit.
				if (w.slot_index < SLOTS) begin
					done_map[w.slot_index] = 1'b1;
				end
			end
			MODE_RELEASE: begin
				if (w.slot_index < SLOTS && held_map[w.slot_index]) begin
					held_map[w.slot_index] = 1'b0;
					if (live_count != 16'd0) begin
						live_count = live_count - 16'd1;
					end
				end
			end
			MODE_RESET: begin
				fill_bytes = '0;
				id_cursor = 0;
				live_count = '0;
				gen_count = gen_count + 32'd1;
				held_map = '0;
				done_map = '0;
			end
			default: begin
			end
		endcase
		r.submit_ready = ((held_map & ~done_map) == '0);
		r.active_slots = live_count;
		r.epoch = gen_count;
		r.used_bytes = fill_bytes;
		return r;
	endfunction

	// Result words are retired before the request of the same edge is added,
	// since a request never yields its word at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_bytes = BufResetBytes;
			fill_bytes = '0;
			id_cursor = 0;
			live_count = '0;
			gen_count = '0;
			held_map = '0;
			done_map = '0;
			owed_results.delete();
			words_owed <= 0;
		end else begin
			if (cfg_wr_en) begin
				cap_bytes = cfg_wr_data;
			end
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					note_mismatch("result word with none owed, used_bytes",
						32'(out_word.used_bytes), '0);
				end else begin
					oldest = owed_results.pop_front();
					match_field("status", 32'(out_word.status), 32'(oldest.status));
					match_field("offset", 32'(out_word.offset), 32'(oldest.offset));
					match_field("granted_slot", 32'(out_word.granted_slot),
						32'(oldest.granted_slot));
					match_field("slot_tracked", 32'(out_word.slot_tracked),
						32'(oldest.slot_tracked));
					match_field("submit_ready", 32'(out_word.submit_ready),
						32'(oldest.submit_ready));
					match_field("active_slots", 32'(out_word.active_slots),
						32'(oldest.active_slots));
					match_field("epoch", out_word.epoch, oldest.epoch);
					match_field("used_bytes", 32'(out_word.used_bytes),
						32'(oldest.used_bytes));
				end
			end
			if (in_valid && !in_stall) begin
				owed_results.insert(owed_results.size(), allocate_step(in_word));
			end
			words_owed <= owed_results.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot tracker testbench
// Drives directed and random request words into the slot tracker under random
// idling on both sides, rewrites the buffer capacity between phases, and gives
// the verdict from the failure count of the result checker.
// ----------------------------------------------------------------------------
module tb_top;
	import bbst_pkg::*;

	// The two request codes that the block treats as a query.
	localparam logic [2:0]  MODE_SPARE_LO = 3'd6;
	localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
	localparam int unsigned RANDOM_WORDS  = 2000;
	localparam int unsigned PHASES        = 9;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [24:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;
	int unsigned words_owed;
	int unsigned fail_count;

	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int unsigned capacity;
	int unsigned sent;
	logic [24:0] phase_caps [PHASES];

	bump_buffer_slot_tracker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

	tb_slot_tracker_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.words_owed (words_owed),
		.fail_count (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random in the share of cycles set for the phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic in_word_t make_word(input logic [2:0] mode, input logic [24:0] len,
			input logic [7:0] idx);
		in_word_t w;
		w.mode = mode;
		w.length = len;
		w.slot_index = idx;
		return w;
	endfunction

	// Mostly small lengths, some scaled to the capacity, a few over all 25 bits.
	function automatic logic [24:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) begin
			return 25'($urandom_range(64));
		end else if (r < 85) begin
			return 25'($urandom_range(capacity / 8));
		end
		return 25'($urandom);
	endfunction

	// Slot ids are mostly in the table, sometimes past it.
	function automatic logic [7:0] pick_slot();
		if ($urandom_range(99) < 80) begin
			return 8'($urandom_range(SlotCountDef - 1));
		end
		return 8'($urandom_range(255, SlotCountDef));
	endfunction

	// One loose request word; fields a request does not use are left random.
	function automatic in_word_t loose_word();
		int unsigned r;
		in_word_t    w;
		r = $urandom_range(99);
		w = make_word(MODE_QUERY, 25'($urandom), 8'($urandom));
		if (r < 30) begin
			w.mode = MODE_RESERVE;
			w.length = pick_length();
		end else if (r < 55) begin
			w.mode = MODE_ALLOC;
			w.length = pick_length();
		end else if (r < 70) begin
			w.mode = MODE_COMPLETE;
			w.slot_index = pick_slot();
		end else if (r < 85) begin
			w.mode = MODE_RELEASE;
			w.slot_index = pick_slot();
		end else if (r < 88) begin
			w.mode = MODE_RESET;
		end else if (r < 94) begin
			w.mode = MODE_QUERY;
		end else if (r < 97) begin
			w.mode = MODE_SPARE_LO;
		end else begin
			w.mode = MODE_SPARE_HI;
		end
		return w;
	endfunction

	// Sends one word after a random gap and waits until it is taken.
	task automatic push_word(input in_word_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// Holds off the sender until every owed result word has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_capacity(input logic [24:0] bytes);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= bytes;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity = 32'(bytes);
	endtask

	// A run of allocations followed by completions and releases of the table.
	task automatic run_batch(input int unsigned count);
		int unsigned k;
		for (k = 0; k < count; k++) begin
			push_word(make_word(MODE_ALLOC, 25'($urandom_range(64)), 8'($urandom)));
		end
		for (k = 0; k < count / 2 + 1; k++) begin
			push_word(make_word(MODE_COMPLETE, 25'($urandom), pick_slot()));
		end
		for (k = 0; k < count / 2 + 1; k++) begin
			push_word(make_word(MODE_RELEASE, 25'($urandom), pick_slot()));
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int unsigned p;
		int unsigned goal;
		int unsigned start;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		send_gap_pct = 23;
		recv_stall_pct = 80;
		capacity = 32'(BufResetBytes);
		sent = 0;
		phase_caps = '{25'h1FFFFFF, 25'd0, 25'd4096, 25'd16777216, 25'd100,
			25'h1FFFFFF, 25'($urandom), BufResetBytes, 25'd65536};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the capacity left by reset.
		push_word(make_word(MODE_QUERY, 25'd0, 8'd0));
		push_word(make_word(MODE_SPARE_LO, 25'h1FFFFFF, 8'hFF));
		push_word(make_word(MODE_SPARE_HI, 25'd0, 8'd0));
		push_word(make_word(MODE_RESERVE, 25'd0, 8'd0));
		push_word(make_word(MODE_RESERVE, 25'd1000, 8'd0));
		push_word(make_word(MODE_ALLOC, 25'd16, 8'd0));
		push_word(make_word(MODE_ALLOC, 25'd0, 8'd0));
		push_word(make_word(MODE_COMPLETE, 25'd0, 8'd0));
		push_word(make_word(MODE_COMPLETE, 25'd0, 8'd255));
		// Completion of an entry that was never allocated.
		push_word(make_word(MODE_COMPLETE, 25'd0, 8'd63));
		push_word(make_word(MODE_RELEASE, 25'd0, 8'd1));
		push_word(make_word(MODE_RELEASE, 25'd0, 8'd1));
		push_word(make_word(MODE_RELEASE, 25'd0, 8'd64));
		push_word(make_word(MODE_RELEASE, 25'd0, 8'd0));
		// Release with no active slot left must not wrap the count.
		push_word(make_word(MODE_RELEASE, 25'd0, 8'd0));
		push_word(make_word(MODE_RESERVE, 25'h1FFFFFF, 8'd0));
		push_word(make_word(MODE_RESET, 25'd0, 8'd0));
		// Exact fill, then a reserve and an allocation that cannot fit.
		push_word(make_word(MODE_RESERVE, BufResetBytes, 8'd0));
		push_word(make_word(MODE_RESERVE, 25'd1, 8'd0));
		push_word(make_word(MODE_ALLOC, 25'd1, 8'd0));
		push_word(make_word(MODE_ALLOC, 25'd0, 8'd0));
		push_word(make_word(MODE_RESET, 25'd0, 8'd0));
		// Fill the table, run past its end, and reuse id 0 while still held.
		run_batch(66);
		push_word(make_word(MODE_RESET, 25'd0, 8'd0));

		// Random phases, each at its own capacity.
		start = sent;
		for (p = 0; p < PHASES; p++) begin
			if (p == 3) begin
				send_gap_pct = 80;
				recv_stall_pct = 23;
			end else if (p == 6) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			set_capacity(phase_caps[p]);
			goal = start + (p + 1) * RANDOM_WORDS / PHASES;
			while (sent < goal) begin
				if ($urandom_range(99) < 6) begin
					run_batch($urandom_range(70, 1));
				end else begin
					push_word(loose_word());
				end
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#(64'd5_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
